// ===== rtl/ixp_pkg.sv =====
// Shared constants, codes and types of the interleaved XOR parity encoder.
package ixp_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int MAX_DEPTH        = 8;

  localparam int PB_W       = $clog2(MAX_PACKET_BYTES + 1);
  localparam int POS_W      = $clog2(MAX_PACKET_BYTES);
  localparam int ROW_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int MEM_DEPTH  = MAX_DEPTH * MAX_PACKET_BYTES;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  localparam int LEN_W      = 4;
  localparam int DEPTH_W    = 4;
  localparam int OFF_W      = 7;
  localparam int PREV_W     = 12;
  localparam int SEQ_W      = 32;
  localparam int CFG_W      = 4;
  localparam int CFG_ADDR_W = 1;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PARITY,
    KIND_EMPTY,
    KIND_REFUSED
  } kind_t;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERLEAVE_DEPTH = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } pmem_wr_t;

endpackage

// ===== rtl/ixp_parity_mem.sv =====
// Parity row memory with registered read and write-to-read forwarding.
module ixp_parity_mem import ixp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  pmem_wr_t          wr,
  output logic [7:0]        cur_byte
);

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              fwd_v_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [7:0]        fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // last write holds current contents of its address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (wr.en) begin
      fwd_v_r <= 1'b1;
    end
    if (wr.en) begin
      fwd_addr_r <= wr.addr;
      fwd_data_r <= wr.data;
    end
  end

  assign cur_byte = (fwd_v_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : rdata_r;

endmodule

// ===== rtl/interleaved_xor_parity_encoder.sv =====
// Interleaved XOR parity encoder: one word in, one word out.
// An accepted word is registered in stage 1 and then in the output register before it is valid on out_*.
// Throughput: one word per cycle while out_tready does not stall a full pipeline; each byte makes
// one read-modify-write of the single-port-per-direction parity memory, with forwarding between neighbors.
// Reset (rst_n, synchronous) clears control state; parity memory is not cleared.
module interleaved_xor_parity_encoder import ixp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] command
  input  logic                  in_tlast,   // end_of_packet
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] byte_out, [8] start_flag, [40:9] packet_number, [47:41] block_offset,
  // [51:48] length_out, [55:52] depth_out, [67:56] previous_length,
  // [68] overflow_flag, [71:69] zero
  output logic [71:0]           out_tdata,
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast,  // last_flag
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int TOT_W = OFF_W + 1;
  localparam int DR_W  = DEPTH_W + 1;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          byte_out;
    logic                start;
    logic                last;
    logic [SEQ_W-1:0]    pn;
    logic [OFF_W-1:0]    off;
    logic [LEN_W-1:0]    len;
    logic [DEPTH_W-1:0]  dep;
    logic [PREV_W-1:0]   prev;
    logic                ovf;
  } res_t;

  // control state
  logic [CFG_W-1:0]   cfg_len_r, cfg_dep_r;
  logic [LEN_W-1:0]   act_len_r, act_len_nxt;
  logic [DEPTH_W-1:0] act_dep_r, act_dep_nxt;
  logic [OFF_W-1:0]   tot_r, tot_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [OFF_W-1:0]   pib_r, pib_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [PB_W-1:0]    byte_pos_r, byte_pos_nxt;
  logic               pending_r, pending_nxt;
  logic [ROW_W-1:0]   drain_row_r, drain_row_nxt;
  logic [POS_W-1:0]   drain_pos_r, drain_pos_nxt;
  logic [PB_W-1:0]    row_len_r [MAX_DEPTH];
  logic [PB_W-1:0]    row_len_nxt [MAX_DEPTH];
  logic [PB_W-1:0]    row_last_r [MAX_DEPTH];
  logic [PB_W-1:0]    row_last_nxt [MAX_DEPTH];

  // stage 1 and output
  logic               s1_v_r;
  res_t               s1_res_r;
  logic               s1_mem_r, s1_wen_r, s1_xor_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic               out_v_r;
  res_t               out_r;

  logic               in_acc, s1_adv;
  res_t               res0, s1_final;
  logic               mem0, wen0, xor0;
  logic [ADDR_W-1:0]  addr0;
  logic [7:0]         cur_byte;
  pmem_wr_t           wr;

  logic               blk_start, first_in_row, ovf, drain_last;
  logic [LEN_W-1:0]   cfg_len_eff, eff_len;
  logic [DEPTH_W-1:0] cfg_dep_eff, eff_dep;
  logic [OFF_W-1:0]   eff_tot;
  logic [ROW_W-1:0]   row0, rsel;
  logic [POS_W-1:0]   pos_sel;
  logic [PB_W-1:0]    rl, rlast, bp_inc, pktlen;

  assign in_tready = !s1_v_r || !out_v_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);

  assign blk_start   = (byte_pos_r == '0) && (pib_r == '0);
  assign cfg_len_eff = (cfg_len_r == '0) ? LEN_W'(1) : LEN_W'(cfg_len_r);
  assign cfg_dep_eff = ({1'b0, cfg_dep_r} > (CFG_W+1)'(MAX_DEPTH)) ?
                       DEPTH_W'(MAX_DEPTH) : DEPTH_W'(cfg_dep_r);
  assign eff_len     = blk_start ? cfg_len_eff : act_len_r;
  assign eff_dep     = blk_start ? cfg_dep_eff : act_dep_r;
  assign eff_tot     = blk_start ? OFF_W'(cfg_len_eff * cfg_dep_eff) : tot_r;
  assign row0        = blk_start ? '0 : cur_row_r;

  assign rsel    = (in_tuser == CMD_DRAIN) ? drain_row_r : row0;
  assign pos_sel = (in_tuser == CMD_DRAIN) ? drain_pos_r : byte_pos_r[POS_W-1:0];
  assign addr0   = ADDR_W'(rsel) * ADDR_W'(MAX_PACKET_BYTES) + ADDR_W'(pos_sel);
  assign rl      = row_len_r[rsel];
  assign rlast   = row_last_r[rsel];

  assign first_in_row = pib_r < OFF_W'(eff_dep);
  assign ovf          = byte_pos_r >= PB_W'(MAX_PACKET_BYTES);
  assign bp_inc       = byte_pos_r + PB_W'(1);
  assign pktlen       = ovf ? byte_pos_r : bp_inc;
  assign drain_last   = (PB_W'(drain_pos_r) + PB_W'(1)) >= rl;

  always_comb begin
    act_len_nxt   = act_len_r;
    act_dep_nxt   = act_dep_r;
    tot_nxt       = tot_r;
    seq_nxt       = seq_r;
    pib_nxt       = pib_r;
    cur_row_nxt   = cur_row_r;
    byte_pos_nxt  = byte_pos_r;
    pending_nxt   = pending_r;
    drain_row_nxt = drain_row_r;
    drain_pos_nxt = drain_pos_r;
    row_len_nxt   = row_len_r;
    row_last_nxt  = row_last_r;
    res0          = '0;
    res0.kind     = KIND_EMPTY;
    mem0          = 1'b0;
    wen0          = 1'b0;
    xor0          = 1'b0;
    if (in_tuser == CMD_DRAIN) begin
      if (pending_r) begin
        res0.kind  = KIND_PARITY;
        mem0       = 1'b1;
        res0.start = (drain_pos_r == '0);
        res0.last  = drain_last;
        res0.pn    = seq_r;
        res0.off   = tot_r + OFF_W'(drain_row_r);
        res0.len   = act_len_r;
        res0.dep   = act_dep_r;
        res0.prev  = PREV_W'(rlast);
        if (drain_last) begin
          seq_nxt       = seq_r + SEQ_W'(1);
          drain_pos_nxt = '0;
          if ((DR_W'(drain_row_r) + DR_W'(1)) >= DR_W'(act_dep_r)) begin
            pending_nxt   = 1'b0;
            drain_row_nxt = '0;
            pib_nxt       = '0;
            cur_row_nxt   = '0;
          end else begin
            drain_row_nxt = drain_row_r + ROW_W'(1);
          end
        end else begin
          drain_pos_nxt = drain_pos_r + POS_W'(1);
        end
      end
    end else if (pending_r) begin
      res0.kind = KIND_REFUSED;
    end else begin
      if (blk_start) begin
        act_len_nxt = cfg_len_eff;
        act_dep_nxt = cfg_dep_eff;
        tot_nxt     = eff_tot;
        cur_row_nxt = '0;
      end
      res0.kind = KIND_DATA;
      res0.last = in_tlast;
      res0.pn   = seq_r;
      res0.off  = pib_r;
      res0.len  = eff_len;
      res0.dep  = eff_dep;
      res0.prev = ((eff_dep != '0) && !first_in_row) ? PREV_W'(rlast) : '0;
      if (!ovf) begin
        res0.byte_out = in_tdata;
        res0.start    = (byte_pos_r == '0);
        if (eff_dep != '0) begin
          wen0 = 1'b1;
          xor0 = !(first_in_row || (byte_pos_r >= rl));
          if (first_in_row || (byte_pos_r >= rl)) begin
            row_len_nxt[row0] = bp_inc;
          end
        end
        byte_pos_nxt = bp_inc;
      end else begin
        res0.ovf = 1'b1;
      end
      if (in_tlast) begin
        byte_pos_nxt = '0;
        seq_nxt      = seq_r + SEQ_W'(1);
        if (eff_dep != '0) begin
          row_last_nxt[row0] = pktlen;
          if ((TOT_W'(pib_r) + TOT_W'(1)) >= TOT_W'(eff_tot)) begin
            pending_nxt   = 1'b1;
            drain_row_nxt = '0;
            drain_pos_nxt = '0;
          end else begin
            pib_nxt = pib_r + OFF_W'(1);
            if ((DR_W'(row0) + DR_W'(1)) >= DR_W'(eff_dep)) begin
              cur_row_nxt = '0;
            end else begin
              cur_row_nxt = row0 + ROW_W'(1);
            end
          end
        end else begin
          pib_nxt     = '0;
          cur_row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= CFG_W'(4);
      cfg_dep_r   <= CFG_W'(1);
      act_len_r   <= LEN_W'(1);
      act_dep_r   <= '0;
      tot_r       <= '0;
      seq_r       <= '0;
      pib_r       <= '0;
      cur_row_r   <= '0;
      byte_pos_r  <= '0;
      pending_r   <= 1'b0;
      drain_row_r <= '0;
      drain_pos_r <= '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        row_len_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BLOCK_LENGTH:     cfg_len_r <= cfg_wdata;
          REG_INTERLEAVE_DEPTH: cfg_dep_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        act_len_r   <= act_len_nxt;
        act_dep_r   <= act_dep_nxt;
        tot_r       <= tot_nxt;
        seq_r       <= seq_nxt;
        pib_r       <= pib_nxt;
        cur_row_r   <= cur_row_nxt;
        byte_pos_r  <= byte_pos_nxt;
        pending_r   <= pending_nxt;
        drain_row_r <= drain_row_nxt;
        drain_pos_r <= drain_pos_nxt;
        row_len_r   <= row_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_last_r <= row_last_nxt;
    end
  end

  // stage 1: memory data arrives, parity byte updated and written back
  ixp_parity_mem u_pmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (addr0),
    .wr       (wr),
    .cur_byte (cur_byte)
  );

  always_comb begin
    s1_final = s1_res_r;
    if (s1_mem_r) begin
      s1_final.byte_out = cur_byte;
    end
    wr.en   = s1_adv && s1_wen_r;
    wr.addr = s1_addr_r;
    wr.data = s1_xor_r ? (cur_byte ^ s1_res_r.byte_out) : s1_res_r.byte_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
    if (in_acc) begin
      s1_res_r  <= res0;
      s1_mem_r  <= mem0;
      s1_wen_r  <= wen0;
      s1_xor_r  <= xor0;
      s1_addr_r <= addr0;
    end
    if (s1_adv) begin
      out_r <= s1_final;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {3'b000, out_r.ovf, out_r.prev, out_r.dep, out_r.len, out_r.off,
                       out_r.pn, out_r.start, out_r.byte_out};

endmodule

// ===== sim/tb_interleaved_xor_parity_encoder.sv =====
// Self-checking testbench of the interleaved XOR parity encoder: directed table, then random blocks.
`timescale 1ns / 100ps

module tb_interleaved_xor_parity_encoder;
  import ixp_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_WORDS  = 1300;
  localparam int HOLD_EVERY  = 700;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic        start_flag;
    logic        last_flag;
    logic [31:0] packet_number;
    logic [6:0]  block_offset;
    logic [3:0]  length_out;
    logic [3:0]  depth_out;
    logic [11:0] previous_length;
    logic        overflow_flag;
  } enc_res_t;

  typedef struct {
    logic     cmd;
    logic [7:0] data;
    logic     eop;
    bit       fixed;
    enc_res_t res;
  } word_t;

  typedef struct {
    logic     cmd;
    logic [7:0] data;
    logic     eop;
    int       reps;
    bit       fixed;
    enc_res_t res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire  [71:0]           out_tdata;
  wire  [1:0]            out_tuser;
  wire                   out_tlast;

  interleaved_xor_parity_encoder dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // encoder state mirror
  logic [7:0]  par_mem [MEM_DEPTH];
  int unsigned row_len [MAX_DEPTH];
  int unsigned row_last [MAX_DEPTH];
  logic [31:0] seq_num = '0;
  int unsigned blk_pos = 0;
  int unsigned cur_row = 0;
  int unsigned byte_pos = 0;
  bit          pend = 1'b0;
  int unsigned drn_row = 0;
  int unsigned drn_pos = 0;
  int unsigned cfg_len = 4;
  int unsigned cfg_dep = 1;
  int unsigned act_len = 1;
  int unsigned act_dep = 0;

  // generator view of the block in progress
  int unsigned g_len = 1;
  int unsigned g_dep = 0;
  int unsigned g_pkt = 0;
  int unsigned g_rowmax [MAX_DEPTH];
  int          rand_words = 0;

  word_t    send_q [$];
  enc_res_t encoded_q [$];
  word_t    cur_word;
  enc_res_t pred_res;
  enc_res_t got_res;
  enc_res_t want_res;
  int       gap_left = 0;
  int       burst_left = 0;
  int       rx_count = 0;
  int       hold_left = 0;
  int       rx_tick = 0;
  int       rx_mode = 0;
  int       idle_cycles = 0;
  int       errors = 0;

  initial begin
    foreach (row_len[i]) begin
      row_len[i] = 0;
      row_last[i] = 0;
      g_rowmax[i] = 0;
    end
  end

  function automatic enc_res_t mk_res(kind_t k, logic [7:0] b, logic st, logic la,
                                      logic [31:0] pn, logic [6:0] off, logic [3:0] len,
                                      logic [3:0] dep, logic [11:0] prev, logic ovf);
    enc_res_t r;
    r.kind = k;
    r.byte_out = b;
    r.start_flag = st;
    r.last_flag = la;
    r.packet_number = pn;
    r.block_offset = off;
    r.length_out = len;
    r.depth_out = dep;
    r.previous_length = prev;
    r.overflow_flag = ovf;
    return r;
  endfunction

  function automatic dir_row_t row(logic cmd, logic [7:0] data, logic eop, int reps,
                                   bit fixed, enc_res_t res);
    dir_row_t d;
    d.cmd = cmd;
    d.data = data;
    d.eop = eop;
    d.reps = reps;
    d.fixed = fixed;
    d.res = res;
    return d;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] v;
    v = $urandom;
    return v[7:0];
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 63) == 0) return $urandom_range(100, 300);
    if ($urandom_range(0, 7) == 0) return $urandom_range(7, 40);
    return $urandom_range(1, 6);
  endfunction

  // one word through the encoder: pass-through/parity/empty/refused
  function automatic enc_res_t encode_word(logic cmd, logic [7:0] b, logic eop);
    enc_res_t    r;
    int unsigned row_i, pos, rl, addr, off, prev, pkt;
    bit          last, ovf, first;
    r = '0;
    if (cmd == CMD_DRAIN) begin
      if (!pend || drn_row >= MAX_DEPTH) begin
        r.kind = KIND_EMPTY;
        return r;
      end
      row_i = drn_row;
      pos = drn_pos;
      rl = row_len[row_i];
      addr = row_i * MAX_PACKET_BYTES + (pos < MAX_PACKET_BYTES ? pos : 0);
      last = (pos + 1 >= rl);
      off = act_len * act_dep + row_i;
      prev = row_last[row_i];
      r = mk_res(KIND_PARITY, par_mem[addr], pos == 0, last, seq_num, off[6:0],
                 act_len[3:0], act_dep[3:0], prev[11:0], 1'b0);
      if (last) begin
        seq_num++;
        drn_pos = 0;
        drn_row++;
        if (drn_row >= act_dep) begin
          pend = 1'b0;
          drn_row = 0;
          blk_pos = 0;
          cur_row = 0;
        end
      end else begin
        drn_pos++;
      end
      return r;
    end

    if (pend) begin
      r.kind = KIND_REFUSED;
      return r;
    end

    if (byte_pos == 0 && blk_pos == 0) begin
      act_len = (cfg_len == 0) ? 1 : cfg_len;
      act_dep = (cfg_dep > MAX_DEPTH) ? MAX_DEPTH : cfg_dep;
      cur_row = 0;
    end
    row_i = (cur_row < MAX_DEPTH) ? cur_row : 0;
    first = blk_pos < act_dep;
    prev = (act_dep > 0 && !first) ? row_last[row_i] : 0;
    ovf = byte_pos >= MAX_PACKET_BYTES;

    r.kind = KIND_DATA;
    r.last_flag = eop;
    r.packet_number = seq_num;
    r.block_offset = blk_pos[6:0];
    r.length_out = act_len[3:0];
    r.depth_out = act_dep[3:0];
    r.previous_length = prev[11:0];
    if (!ovf) begin
      r.byte_out = b;
      r.start_flag = (byte_pos == 0);
      if (act_dep > 0) begin
        addr = row_i * MAX_PACKET_BYTES + byte_pos;
        if (first || byte_pos >= row_len[row_i]) begin
          par_mem[addr] = b;
          if (first || byte_pos + 1 > row_len[row_i]) row_len[row_i] = byte_pos + 1;
        end else begin
          par_mem[addr] = par_mem[addr] ^ b;
        end
      end
      byte_pos++;
    end else begin
      r.overflow_flag = 1'b1;
    end

    if (eop) begin
      pkt = byte_pos;
      byte_pos = 0;
      seq_num++;
      if (act_dep > 0) begin
        row_last[row_i] = pkt;
        if (blk_pos + 1 >= act_len * act_dep) begin
          pend = 1'b1;
          drn_row = 0;
          drn_pos = 0;
        end else begin
          blk_pos++;
          cur_row = (cur_row + 1 >= act_dep) ? 0 : cur_row + 1;
        end
      end else begin
        blk_pos = 0;
        cur_row = 0;
      end
    end
    return r;
  endfunction

  task automatic push_word(logic cmd, logic [7:0] data, logic eop);
    word_t w;
    w.cmd = cmd;
    w.data = data;
    w.eop = eop;
    w.fixed = 1'b0;
    w.res = '0;
    send_q.push_back(w);
  endtask

  // one well-formed packet; parity drains follow once the block is full
  task automatic gen_packet(int len);
    int unsigned r, capped, owe;
    if (g_pkt == 0) begin
      g_len = (cfg_len == 0) ? 1 : cfg_len;
      g_dep = (cfg_dep > MAX_DEPTH) ? MAX_DEPTH : cfg_dep;
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_word(CMD_DRAIN, rand_byte(), $urandom_range(0, 1) == 1);
        rand_words++;
      end
      push_word(CMD_DATA, rand_byte(), i == len - 1);
      rand_words++;
    end
    if (g_dep > 0) begin
      r = g_pkt % g_dep;
      capped = (len > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : len;
      if (g_pkt < g_dep || capped > g_rowmax[r]) g_rowmax[r] = capped;
      g_pkt++;
      if (g_pkt >= g_len * g_dep) begin
        owe = 0;
        for (int k = 0; k < g_dep; k++) owe += g_rowmax[k];
        for (int k = 0; k < owe; k++) begin
          if ($urandom_range(0, 9) == 0)
            push_word(CMD_DATA, rand_byte(), $urandom_range(0, 1) == 1);
          push_word(CMD_DRAIN, rand_byte(), $urandom_range(0, 1) == 1);
          rand_words++;
        end
        repeat ($urandom_range(0, 2)) push_word(CMD_DRAIN, rand_byte(), 1'b0);
        g_pkt = 0;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (send_q.size() != 0 || in_tvalid || encoded_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (a == REG_BLOCK_LENGTH) cfg_len = d;
    else if (a == REG_INTERLEAVE_DEPTH) cfg_dep = d;
    @(negedge clk);
  endtask

  task automatic run_phase(int len, int dep, int npk);
    write_reg(REG_BLOCK_LENGTH, len[3:0]);
    write_reg(REG_INTERLEAVE_DEPTH, dep[3:0]);
    repeat (npk) gen_packet(pick_len());
    wait_idle();
  endtask

  task automatic report(string fld, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("result %0d: %s got %0h want %0h", rx_count, fld, got, want);
  endtask

  // sender: bursts with random gaps, holds the word while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred_res = encode_word(cur_word.cmd, cur_word.data, cur_word.eop);
        encoded_q.push_back(cur_word.fixed ? cur_word.res : pred_res);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (send_q.size() > 0) begin
          cur_word = send_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_word.data;
          in_tuser <= cur_word.cmd;
          in_tlast <= cur_word.eop;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 31);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each word, stalls on its own pattern, long hold now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res.kind = kind_t'(out_tuser);
        got_res.byte_out = out_tdata[7:0];
        got_res.start_flag = out_tdata[8];
        got_res.packet_number = out_tdata[40:9];
        got_res.block_offset = out_tdata[47:41];
        got_res.length_out = out_tdata[51:48];
        got_res.depth_out = out_tdata[55:52];
        got_res.previous_length = out_tdata[67:56];
        got_res.overflow_flag = out_tdata[68];
        got_res.last_flag = out_tlast;
        if (encoded_q.size() == 0) begin
          report("unexpected word", 32'd0, 32'd0);
        end else begin
          want_res = encoded_q.pop_front();
          if (got_res.kind !== want_res.kind)
            report("kind", got_res.kind, want_res.kind);
          if (got_res.byte_out !== want_res.byte_out)
            report("byte_out", got_res.byte_out, want_res.byte_out);
          if (got_res.start_flag !== want_res.start_flag)
            report("start_flag", got_res.start_flag, want_res.start_flag);
          if (got_res.last_flag !== want_res.last_flag)
            report("last_flag", got_res.last_flag, want_res.last_flag);
          if (got_res.packet_number !== want_res.packet_number)
            report("packet_number", got_res.packet_number, want_res.packet_number);
          if (got_res.block_offset !== want_res.block_offset)
            report("block_offset", got_res.block_offset, want_res.block_offset);
          if (got_res.length_out !== want_res.length_out)
            report("length_out", got_res.length_out, want_res.length_out);
          if (got_res.depth_out !== want_res.depth_out)
            report("depth_out", got_res.depth_out, want_res.depth_out);
          if (got_res.previous_length !== want_res.previous_length)
            report("previous_length", got_res.previous_length, want_res.previous_length);
          if (got_res.overflow_flag !== want_res.overflow_flag)
            report("overflow_flag", got_res.overflow_flag, want_res.overflow_flag);
        end
        rx_count++;
        if (rx_count % HOLD_EVERY == 0) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        rx_tick++;
        if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t tab [$];
    word_t    w;
    enc_res_t empty_r;
    enc_res_t refused_r;
    empty_r = mk_res(KIND_EMPTY, 8'h00, 1'b0, 1'b0, 32'd0, 7'd0, 4'd0, 4'd0, 12'd0, 1'b0);
    refused_r = mk_res(KIND_REFUSED, 8'h00, 1'b0, 1'b0, 32'd0, 7'd0, 4'd0, 4'd0, 12'd0, 1'b0);

    // reset config: length 4, depth 1
    tab.push_back(row(CMD_DRAIN, 8'h00, 1'b0, 1, 1'b1, empty_r));
    tab.push_back(row(CMD_DATA, 8'h00, 1'b0, 1, 1'b1,
                      mk_res(KIND_DATA, 8'h00, 1'b1, 1'b0, 32'd0, 7'd0, 4'd4, 4'd1,
                             12'd0, 1'b0)));
    tab.push_back(row(CMD_DATA, 8'hFF, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'hA5, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h81, 1'b0, 1, 1'b0, '0));
    tab.push_back(row(CMD_DRAIN, 8'hFF, 1'b1, 1, 1'b1, empty_r));
    tab.push_back(row(CMD_DATA, 8'h7E, 1'b0, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h01, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h5A, 1'b1, 1, 1'b0, '0));
    // parity owed: data refused, eop ignored
    tab.push_back(row(CMD_DATA, 8'h33, 1'b1, 1, 1'b1, refused_r));
    tab.push_back(row(CMD_DATA, 8'hCC, 1'b0, 1, 1'b1, refused_r));
    tab.push_back(row(CMD_DRAIN, 8'h00, 1'b0, 3, 1'b0, '0));
    tab.push_back(row(CMD_DRAIN, 8'h00, 1'b0, 1, 1'b1, empty_r));
    // oversize packet, then a row whose previous length saturated
    tab.push_back(row(CMD_DATA, 8'h3C, 1'b0, MAX_PACKET_BYTES, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'hC3, 1'b0, 2, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h96, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h10, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h20, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DATA, 8'h30, 1'b1, 1, 1'b0, '0));
    tab.push_back(row(CMD_DRAIN, 8'h00, 1'b0, MAX_PACKET_BYTES, 1'b0, '0));
    tab.push_back(row(CMD_DRAIN, 8'h00, 1'b0, 1, 1'b1, empty_r));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (tab[i]) begin
      repeat (tab[i].reps) begin
        w.cmd = tab[i].cmd;
        w.data = tab[i].data;
        w.eop = tab[i].eop;
        w.fixed = tab[i].fixed;
        w.res = tab[i].res;
        send_q.push_back(w);
      end
    end
    wait_idle();

    run_phase(15, 8, 120);
    run_phase(1, 0, 5);
    run_phase(15, 0, 5);
    run_phase(1, 1, 3);
    run_phase(1, 8, 8);
    // block left two of six packets done, new values wait for the next block
    run_phase(3, 2, 2);
    run_phase(2, 4, 4);

    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      run_phase(($urandom_range(0, 4) == 0) ? 1 :
                  (($urandom_range(0, 3) == 0) ? 15 : $urandom_range(1, 15)),
                $urandom_range(0, 8), $urandom_range(1, 40));
    end

    repeat (8) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ixp_pkg.sv
rtl/ixp_parity_mem.sv
rtl/interleaved_xor_parity_encoder.sv
sim/tb_interleaved_xor_parity_encoder.sv
